FILE: rtl/rgp_pkg.sv
package rgp_pkg;

   localparam int TGT_W   = 10;
   localparam int FF_W    = 16;
   localparam int RAD_W   = 24;
   localparam int GAIN_W  = 18;
   localparam int NUM_CH  = 3;
   localparam int SCALE_W = GAIN_W + RAD_W - 16;

   // 1.0 in q2.16
   localparam logic [GAIN_W-1:0] GAIN_ONE = 18'd65536;
   localparam logic [RAD_W-1:0]  RAD_MAX  = 24'hFFFFFF;

   typedef logic [NUM_CH-1:0][FF_W-1:0]  rgb16_type;
   typedef logic [NUM_CH-1:0][RAD_W-1:0] rgb24_type;

   typedef struct packed {
      logic ld_fd;
      logic ld_term;
      logic acc_add;
      logic acc_clear;
      logic ld_scaled;
   } ctl_type;

endpackage

FILE: rtl/rgp_if.sv
interface rgp_req_if;
   import rgp_pkg::*;

   logic              valid;
   logic              ready;
   logic [TGT_W-1:0]  target_plane;
   logic [FF_W-1:0]   form_factor;
   logic [FF_W-1:0]   diffuse_r;
   logic [FF_W-1:0]   diffuse_g;
   logic [FF_W-1:0]   diffuse_b;
   logic [RAD_W-1:0]  emit_r;
   logic [RAD_W-1:0]  emit_g;
   logic [RAD_W-1:0]  emit_b;
   logic              has_term;
   logic              last_term;
   logic              last_plane;

   modport source (
      output valid, target_plane, form_factor, diffuse_r, diffuse_g, diffuse_b,
             emit_r, emit_g, emit_b, has_term, last_term, last_plane,
      input  ready
   );
   modport sink (
      input  valid, target_plane, form_factor, diffuse_r, diffuse_g, diffuse_b,
             emit_r, emit_g, emit_b, has_term, last_term, last_plane,
      output ready
   );
endinterface

interface rgp_rsp_if;
   import rgp_pkg::*;

   logic              valid;
   logic              ready;
   logic [TGT_W-1:0]  plane_index;
   logic [RAD_W-1:0]  out_r;
   logic [RAD_W-1:0]  out_g;
   logic [RAD_W-1:0]  out_b;
   logic              pass_done;

   modport source (
      output valid, plane_index, out_r, out_g, out_b, pass_done,
      input  ready
   );
   modport sink (
      input  valid, plane_index, out_r, out_g, out_b, pass_done,
      output ready
   );
endinterface

FILE: rtl/rgp_ram.sv
module rgp_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rgp_math.sv
module rgp_math (
   input  logic                      clock,
   input  logic                      reset,
   input  rgp_pkg::ctl_type          ctl,
   input  logic [15:0]               form_factor,
   input  rgp_pkg::rgb16_type        diffuse,
   input  rgp_pkg::rgb24_type        radiosity,
   input  rgp_pkg::rgb24_type        emit,
   input  logic [17:0]               gain,
   output rgp_pkg::rgb24_type        result
);
   import rgp_pkg::*;

   rgb16_type                       fd_ff, fd_in;
   rgb24_type                       term_ff, term_in;
   rgb24_type                       acc_ff, acc_in;
   logic [NUM_CH-1:0][SCALE_W-1:0]  scaled_ff, scaled_in;

   always_comb begin
      logic [2*FF_W-1:0]          p_fd;
      logic [FF_W+RAD_W-1:0]      p_term;
      logic [RAD_W:0]             sum_acc;
      logic [GAIN_W+RAD_W-1:0]    p_gain;
      logic [SCALE_W:0]           sum_out;
      for (int c = 0; c < NUM_CH; c++) begin
         p_fd         = form_factor * diffuse[c];
         fd_in[c]     = p_fd[2*FF_W-1:16];
         p_term       = fd_ff[c] * radiosity[c];
         term_in[c]   = p_term[FF_W+RAD_W-1:16];
         sum_acc      = {1'b0, acc_ff[c]} + {1'b0, term_ff[c]};
         acc_in[c]    = sum_acc[RAD_W] ? RAD_MAX : sum_acc[RAD_W-1:0];
         p_gain       = gain * acc_ff[c];
         scaled_in[c] = p_gain[GAIN_W+RAD_W-1:16];
         sum_out      = (SCALE_W+1)'(emit[c]) + {1'b0, scaled_ff[c]};
         result[c]    = (sum_out > (SCALE_W+1)'(RAD_MAX)) ? RAD_MAX : sum_out[RAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_fd) begin
         fd_ff <= fd_in;
      end
      if (ctl.ld_term) begin
         term_ff <= term_in;
      end
      if (ctl.ld_scaled) begin
         scaled_ff <= scaled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.acc_clear) begin
         acc_ff <= '0;
      end else if (ctl.acc_add) begin
         acc_ff <= acc_in;
      end
   end

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.acc_clear |=> (acc_ff == '0))
      else $error("accumulators not cleared after write-back");

   a_ctl_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.ld_fd, ctl.ld_term, ctl.acc_add, ctl.acc_clear, ctl.ld_scaled}))
      else $error("more than one datapath step at once");

   a_acc_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.acc_add |=> (acc_ff >= $past(acc_ff)))
      else $error("accumulator decreased on an add");

endmodule

FILE: rtl/radiosity_gather_pass.sv
// channel  dir  handshake        payload
// req_chan in   valid/ready      target_plane, form_factor, diffuse_rgb, emit_rgb, flags
// rsp_chan out  valid/ready      plane_index, out_rgb, pass_done
// csr      in   csr_wr_en        csr_wr_data (reflect_gain, q2.16)
//
// a request with a term steps through MUL1, MUL2 and ACC, then FIN and WB on the last term
// a last term without a term goes to FIN and WB; a request with neither stays in idle
// the two multiplies and the accumulate around the one radiosity memory set this sequence
// after reset the memory is cleared, with req ready low
// a result waits in the output register; write-back stalls only while that register is full
module radiosity_gather_pass #(
   parameter int PLANE_COUNT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   rgp_req_if.sink               req_chan,
   rgp_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [17:0]           csr_wr_data
);
   import rgp_pkg::*;

   localparam int PW    = $clog2(PLANE_COUNT);
   localparam int AW    = PW + 1;
   localparam int DEPTH = 2 ** AW;
   localparam int TW    = PW + TGT_W;
   localparam int MW    = NUM_CH * RAD_W;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_MUL1, S_MUL2, S_ACC, S_FIN, S_WB
   } state_type;

   state_type          state_ff;
   logic [AW-1:0]      clr_addr_ff;
   logic               bank_ff;
   logic [PW-1:0]      plane_cnt_ff;
   logic [GAIN_W-1:0]  reflect_gain_ff;

   logic [FF_W-1:0]    ff_ff;
   rgb16_type          diffuse_ff;
   rgb24_type          emit_ff;
   logic               last_term_ff;
   logic               last_plane_ff;
   logic               in_range_ff;

   logic               rsp_valid_ff;
   logic [TGT_W-1:0]   rsp_plane_ff;
   rgb24_type          rsp_rgb_ff;
   logic               rsp_done_ff;

   logic               req_fire;
   logic               wb_fire;
   logic [TW-1:0]      tgt_wide;
   logic [TW-1:0]      idx_wide;
   logic               ram_we;
   logic [AW-1:0]      ram_wr_addr;
   logic [MW-1:0]      ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [MW-1:0]      ram_rd_data;
   rgb24_type          rad;
   rgb24_type          result;
   ctl_type            ctl;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign wb_fire        = (state_ff == S_WB) && (!rsp_valid_ff || rsp_chan.ready);

   assign tgt_wide    = TW'(req_chan.target_plane);
   assign idx_wide    = TW'(plane_cnt_ff);
   assign ram_rd_addr = {bank_ff, tgt_wide[PW-1:0]};

   assign ram_we      = (state_ff == S_CLEAR) || wb_fire;
   assign ram_wr_addr = (state_ff == S_CLEAR) ? clr_addr_ff : {~bank_ff, plane_cnt_ff};
   assign ram_wr_data = (state_ff == S_CLEAR) ? '0 : {result[2], result[1], result[0]};

   // out-of-range targets read as zero radiosity
   assign rad[0] = in_range_ff ? ram_rd_data[RAD_W-1:0]         : '0;
   assign rad[1] = in_range_ff ? ram_rd_data[2*RAD_W-1:RAD_W]   : '0;
   assign rad[2] = in_range_ff ? ram_rd_data[3*RAD_W-1:2*RAD_W] : '0;

   always_comb begin
      ctl           = '0;
      ctl.ld_fd     = (state_ff == S_MUL1);
      ctl.ld_term   = (state_ff == S_MUL2);
      ctl.acc_add   = (state_ff == S_ACC);
      ctl.ld_scaled = (state_ff == S_FIN);
      ctl.acc_clear = wb_fire;
   end

   rgp_ram #(
      .WIDTH (MW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rgp_math u_math (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .form_factor (ff_ff),
      .diffuse     (diffuse_ff),
      .radiosity   (rad),
      .emit        (emit_ff),
      .gain        (reflect_gain_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         reflect_gain_ff <= GAIN_ONE;
      end else if (csr_wr_en) begin
         reflect_gain_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         bank_ff      <= 1'b0;
         plane_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && !wb_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  ff_ff         <= req_chan.form_factor;
                  diffuse_ff    <= {req_chan.diffuse_b, req_chan.diffuse_g, req_chan.diffuse_r};
                  emit_ff       <= {req_chan.emit_b, req_chan.emit_g, req_chan.emit_r};
                  last_term_ff  <= req_chan.last_term;
                  last_plane_ff <= req_chan.last_plane;
                  in_range_ff   <= (tgt_wide < TW'(PLANE_COUNT));
                  if (req_chan.has_term) begin
                     state_ff <= S_MUL1;
                  end else if (req_chan.last_term) begin
                     state_ff <= S_FIN;
                  end
               end
            end
            S_MUL1: state_ff <= S_MUL2;
            S_MUL2: state_ff <= S_ACC;
            S_ACC:  state_ff <= last_term_ff ? S_FIN : S_IDLE;
            S_FIN:  state_ff <= S_WB;
            S_WB: begin
               if (wb_fire) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_plane_ff <= idx_wide[TGT_W-1:0];
                  rsp_rgb_ff   <= result;
                  rsp_done_ff  <= last_plane_ff;
                  if (last_plane_ff) begin
                     bank_ff      <= ~bank_ff;
                     plane_cnt_ff <= '0;
                  end else if (plane_cnt_ff == PW'(PLANE_COUNT - 1)) begin
                     plane_cnt_ff <= '0;
                  end else begin
                     plane_cnt_ff <= plane_cnt_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.plane_index = rsp_plane_ff;
   assign rsp_chan.out_r       = rsp_rgb_ff[0];
   assign rsp_chan.out_g       = rsp_rgb_ff[1];
   assign rsp_chan.out_b       = rsp_rgb_ff[2];
   assign rsp_chan.pass_done   = rsp_done_ff;

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_chan.ready)
      else $error("request taken during memory clear");

   a_wb_new_bank: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != S_CLEAR) |-> (ram_wr_addr[AW-1] != bank_ff))
      else $error("write-back aimed at the bank being read");

   a_pass_swap: assert property (@(posedge clock) disable iff (reset)
      (wb_fire && last_plane_ff) |=> (bank_ff != $past(bank_ff)) && (plane_cnt_ff == '0))
      else $error("pass end did not swap banks");

   a_rsp_on_wb: assert property (@(posedge clock) disable iff (reset)
      wb_fire |=> rsp_valid_ff)
      else $error("write-back without a result");

endmodule
